### src/igta_pkg.sv
package igta_pkg;

   localparam int MAX_TRACKS_DEF = 16;
   localparam int MAX_DETS_DEF   = 32;
   localparam int COORD_BITS_DEF = 12;
   localparam int FIELD_W        = 12;
   localparam int TAG_W          = 16;
   localparam int CNT_W          = 8;
   localparam int THR_W          = 9;
   localparam int RESULT_LIMIT   = 16;
   localparam int DATA_W         = 4 * FIELD_W + TAG_W;
   localparam int CSR_IDX_W      = 2;

   localparam logic [THR_W-1:0] THR_RESET  = 9'd77;
   localparam logic [CNT_W-1:0] MAXM_RESET = 8'd3;
   localparam logic [CNT_W-1:0] MINH_RESET = 8'd3;
   localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_THRESHOLD   = 2'd0,
      CSR_MAX_MISSED_FRAMES = 2'd1,
      CSR_MIN_HITS_CONFIRM  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRK_START,
      ST_DET_RD,
      ST_OV,
      ST_IN,
      ST_XM,
      ST_BEST,
      ST_ACC,
      ST_UPD,
      ST_CMP,
      ST_NEW,
      ST_SCAN,
      ST_SEND,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic store_det;
      logic eof_start;
      logic trk_load;
      logic det_load;
      logic ov_calc;
      logic in_calc;
      logic xm_calc;
      logic best_upd;
      logic acc_calc;
      logic trk_write;
      logic cmp_init;
      logic cmp_step;
      logic cmp_done;
      logic new_step;
      logic out_init;
      logic scan_step;
      logic final_load;
      logic frame_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic t_end;
      logic i_end;
      logic scan_done;
      logic scan_emit;
      logic out_done;
   } dp_status_type;

endpackage

### src/igta_ctrl.sv
module igta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_cmd,
   input  igta_pkg::dp_status_type status,
   output igta_pkg::dp_cmd_type   cmd
);
   import igta_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept && req_cmd) state_in = ST_TRK_START;
         ST_TRK_START: state_in = status.t_end ? ST_CMP : ST_DET_RD;
         ST_DET_RD:    state_in = status.i_end ? ST_ACC : ST_OV;
         ST_OV:        state_in = ST_IN;
         ST_IN:        state_in = ST_XM;
         ST_XM:        state_in = ST_BEST;
         ST_BEST:      state_in = ST_DET_RD;
         ST_ACC:       state_in = ST_UPD;
         ST_UPD:       state_in = ST_TRK_START;
         ST_CMP:       if (status.t_end) state_in = ST_NEW;
         ST_NEW:       if (status.i_end) state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_LAST;
            else if (status.scan_emit) state_in = ST_SEND;
         end
         ST_SEND:      if (status.out_done) state_in = ST_SCAN;
         ST_LAST:      if (status.out_done) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.store_det = accept && !req_cmd;
            cmd.eof_start = accept && req_cmd;
         end
         ST_TRK_START: begin
            cmd.trk_load = !status.t_end;
            cmd.cmp_init = status.t_end;
         end
         ST_DET_RD: cmd.det_load = !status.i_end;
         ST_OV:     cmd.ov_calc = 1'b1;
         ST_IN:     cmd.in_calc = 1'b1;
         ST_XM:     cmd.xm_calc = 1'b1;
         ST_BEST:   cmd.best_upd = 1'b1;
         ST_ACC:    cmd.acc_calc = 1'b1;
         ST_UPD:    cmd.trk_write = 1'b1;
         ST_CMP: begin
            cmd.cmp_step = !status.t_end;
            cmd.cmp_done = status.t_end;
         end
         ST_NEW: begin
            cmd.new_step = !status.i_end;
            cmd.out_init = status.i_end;
         end
         ST_SCAN: begin
            cmd.scan_step  = !status.scan_done;
            cmd.final_load = status.scan_done;
         end
         ST_SEND: ;
         ST_LAST:   cmd.frame_clear = status.out_done;
         default: ;
      endcase
   end

endmodule

### src/igta_dp.sv
module igta_dp #(
   parameter int MAX_TRACKS = igta_pkg::MAX_TRACKS_DEF,
   parameter int MAX_DETS   = igta_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = igta_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [igta_pkg::DATA_W-1:0]          req_tdata,
   input  logic                                 csr_valid,
   input  logic [igta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [igta_pkg::THR_W-1:0]           csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [igta_pkg::DATA_W-1:0]          rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  igta_pkg::dp_cmd_type                 cmd,
   output igta_pkg::dp_status_type              status
);
   import igta_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int TCW = $clog2(MAX_TRACKS + 1);
   localparam int DIW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
   localparam int DCW = $clog2(MAX_DETS + 1);
   localparam int KW  = $clog2(RESULT_LIMIT + 1);
   localparam int SW  = C + 3;
   localparam int PW  = 2 * C + 2;
   localparam int UW  = 2 * C + 3;
   localparam int XW  = PW + UW;
   localparam int AW  = UW + THR_W;

   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] maxm_ff, minh_ff;

   logic [C-1:0]     trk_x_ff [MAX_TRACKS];
   logic [C-1:0]     trk_y_ff [MAX_TRACKS];
   logic [C-1:0]     trk_w_ff [MAX_TRACKS];
   logic [C-1:0]     trk_h_ff [MAX_TRACKS];
   logic [TAG_W-1:0] trk_tag_ff [MAX_TRACKS];
   logic [CNT_W-1:0] trk_hits_ff [MAX_TRACKS];
   logic [CNT_W-1:0] trk_miss_ff [MAX_TRACKS];
   logic [TCW-1:0]   tc_ff;

   logic [C-1:0]     fr_x_ff [MAX_DETS];
   logic [C-1:0]     fr_y_ff [MAX_DETS];
   logic [C-1:0]     fr_w_ff [MAX_DETS];
   logic [C-1:0]     fr_h_ff [MAX_DETS];
   logic [TAG_W-1:0] fr_tag_ff [MAX_DETS];
   logic [MAX_DETS-1:0] matched_ff;
   logic [DCW-1:0]   fc_ff;
   logic             drop_ff;

   logic [TCW-1:0]   t_ff, n_ff;
   logic [DCW-1:0]   i_ff;
   logic [KW-1:0]    k_ff;

   logic [C-1:0]     cur_x_ff, cur_y_ff, cur_w_ff, cur_h_ff;
   logic [CNT_W-1:0] cur_hits_ff, cur_miss_ff;
   logic [PW-1:0]    ta_ff, da_ff;
   logic [C-1:0]     cand_x_ff, cand_y_ff, cand_w_ff, cand_h_ff;
   logic [TAG_W-1:0] cand_tag_ff;
   logic             cand_m_ff;
   logic signed [SW:0] iw_ff, ih_ff;
   logic [PW-1:0]    ci_ff, bi_ff;
   logic [UW-1:0]    cu_ff, bu_ff;
   logic [XW-1:0]    p1_ff, p2_ff;
   logic [DIW-1:0]   best_ff;
   logic             best_v_ff, match_ff;

   logic             held_v_ff;
   logic [C-1:0]     hd_x_ff, hd_y_ff, hd_w_ff, hd_h_ff;
   logic [TAG_W-1:0] hd_tag_ff;

   logic             ov_ff, pres_ff, last_ff;
   logic [FIELD_W-1:0] o_x_ff, o_y_ff, o_w_ff, o_h_ff;
   logic [TAG_W-1:0] o_tag_ff;

   logic [TIW-1:0]   t_idx, wr_idx;
   logic [DIW-1:0]   rd_idx;
   logic             trk_we, confirmed, keep, out_xfer;
   logic signed [SW-1:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
   logic signed [SW-1:0] lox, hix, loy, hiy;
   logic [PW-1:0]    inter_in;
   logic [C-1:0]     wx_in, wy_in, ww_in, wh_in;
   logic [TAG_W-1:0] wtag_in;
   logic [CNT_W-1:0] whits_in, wmiss_in;

   assign t_idx     = t_ff[TIW-1:0];
   assign rd_idx    = cmd.acc_calc ? best_ff : i_ff[DIW-1:0];
   assign confirmed = trk_hits_ff[t_idx] >= minh_ff;
   assign keep      = trk_miss_ff[t_idx] <= maxm_ff;
   assign out_xfer  = rsp_tvalid && rsp_tready;

   assign status.t_end     = t_ff >= tc_ff;
   assign status.i_end     = i_ff >= fc_ff;
   assign status.scan_done = (t_ff >= tc_ff) || (k_ff == KW'(RESULT_LIMIT));
   assign status.scan_emit = confirmed && held_v_ff;
   assign status.out_done  = out_xfer;

   // corners doubled so all geometry stays integer
   assign ax1 = $signed({2'b00, cur_x_ff, 1'b0}) - $signed({3'b000, cur_w_ff});
   assign ax2 = $signed({2'b00, cur_x_ff, 1'b0}) + $signed({3'b000, cur_w_ff});
   assign ay1 = $signed({2'b00, cur_y_ff, 1'b0}) - $signed({3'b000, cur_h_ff});
   assign ay2 = $signed({2'b00, cur_y_ff, 1'b0}) + $signed({3'b000, cur_h_ff});
   assign bx1 = $signed({2'b00, cand_x_ff, 1'b0}) - $signed({3'b000, cand_w_ff});
   assign bx2 = $signed({2'b00, cand_x_ff, 1'b0}) + $signed({3'b000, cand_w_ff});
   assign by1 = $signed({2'b00, cand_y_ff, 1'b0}) - $signed({3'b000, cand_h_ff});
   assign by2 = $signed({2'b00, cand_y_ff, 1'b0}) + $signed({3'b000, cand_h_ff});
   assign lox = (ax1 > bx1) ? ax1 : bx1;
   assign hix = (ax2 < bx2) ? ax2 : bx2;
   assign loy = (ay1 > by1) ? ay1 : by1;
   assign hiy = (ay2 < by2) ? ay2 : by2;

   assign inter_in = (iw_ff > 0 && ih_ff > 0) ?
                     PW'(iw_ff[C:0]) * PW'(ih_ff[C:0]) : '0;

   // track table write port
   always_comb begin
      trk_we   = 1'b0;
      wr_idx   = t_idx;
      wx_in    = cand_x_ff;
      wy_in    = cand_y_ff;
      ww_in    = cand_w_ff;
      wh_in    = cand_h_ff;
      wtag_in  = cand_tag_ff;
      whits_in = (cur_hits_ff == CNT_MAX) ? CNT_MAX : cur_hits_ff + 1'b1;
      wmiss_in = '0;
      if (cmd.trk_write) begin
         trk_we = 1'b1;
         if (!match_ff) begin
            wx_in    = cur_x_ff;
            wy_in    = cur_y_ff;
            ww_in    = cur_w_ff;
            wh_in    = cur_h_ff;
            wtag_in  = trk_tag_ff[t_idx];
            whits_in = cur_hits_ff;
            wmiss_in = cur_miss_ff;
         end
      end else if (cmd.cmp_step) begin
         trk_we   = keep;
         wr_idx   = n_ff[TIW-1:0];
         wx_in    = trk_x_ff[t_idx];
         wy_in    = trk_y_ff[t_idx];
         ww_in    = trk_w_ff[t_idx];
         wh_in    = trk_h_ff[t_idx];
         wtag_in  = trk_tag_ff[t_idx];
         whits_in = trk_hits_ff[t_idx];
         wmiss_in = trk_miss_ff[t_idx];
      end else if (cmd.new_step) begin
         trk_we   = !matched_ff[rd_idx] && (tc_ff < TCW'(MAX_TRACKS));
         wr_idx   = tc_ff[TIW-1:0];
         wx_in    = fr_x_ff[rd_idx];
         wy_in    = fr_y_ff[rd_idx];
         ww_in    = fr_w_ff[rd_idx];
         wh_in    = fr_h_ff[rd_idx];
         wtag_in  = fr_tag_ff[rd_idx];
         whits_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (trk_we) begin
         trk_x_ff[wr_idx]    <= wx_in;
         trk_y_ff[wr_idx]    <= wy_in;
         trk_w_ff[wr_idx]    <= ww_in;
         trk_h_ff[wr_idx]    <= wh_in;
         trk_tag_ff[wr_idx]  <= wtag_in;
         trk_hits_ff[wr_idx] <= whits_in;
         trk_miss_ff[wr_idx] <= wmiss_in;
      end
      if (cmd.store_det && fc_ff < DCW'(MAX_DETS)) begin
         fr_x_ff[fc_ff[DIW-1:0]]   <= C'(req_tdata[FIELD_W-1:0]);
         fr_y_ff[fc_ff[DIW-1:0]]   <= C'(req_tdata[2*FIELD_W-1:FIELD_W]);
         fr_w_ff[fc_ff[DIW-1:0]]   <= C'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
         fr_h_ff[fc_ff[DIW-1:0]]   <= C'(req_tdata[4*FIELD_W-1:3*FIELD_W]);
         fr_tag_ff[fc_ff[DIW-1:0]] <= req_tdata[DATA_W-1:4*FIELD_W];
      end
   end

   // matching datapath
   always_ff @(posedge clock) begin
      if (cmd.trk_load) begin
         cur_x_ff    <= trk_x_ff[t_idx];
         cur_y_ff    <= trk_y_ff[t_idx];
         cur_w_ff    <= trk_w_ff[t_idx];
         cur_h_ff    <= trk_h_ff[t_idx];
         cur_hits_ff <= trk_hits_ff[t_idx];
         cur_miss_ff <= (trk_miss_ff[t_idx] == CNT_MAX) ? CNT_MAX
                                                        : trk_miss_ff[t_idx] + 1'b1;
         ta_ff       <= {PW'(trk_w_ff[t_idx]) * PW'(trk_h_ff[t_idx])} << 2;
         bi_ff       <= '0;
         bu_ff       <= UW'(1);
         best_ff     <= '0;
      end
      if (cmd.det_load || cmd.acc_calc) begin
         cand_x_ff   <= fr_x_ff[rd_idx];
         cand_y_ff   <= fr_y_ff[rd_idx];
         cand_w_ff   <= fr_w_ff[rd_idx];
         cand_h_ff   <= fr_h_ff[rd_idx];
         cand_tag_ff <= fr_tag_ff[rd_idx];
         cand_m_ff   <= matched_ff[rd_idx];
      end
      if (cmd.ov_calc) begin
         iw_ff <= $signed({hix[SW-1], hix}) - $signed({lox[SW-1], lox});
         ih_ff <= $signed({hiy[SW-1], hiy}) - $signed({loy[SW-1], loy});
         da_ff <= (PW'(cand_w_ff) * PW'(cand_h_ff)) << 2;
      end
      if (cmd.in_calc) begin
         ci_ff <= inter_in;
         cu_ff <= UW'(ta_ff) + UW'(da_ff) - UW'(inter_in);
      end
      if (cmd.xm_calc) begin
         p1_ff <= XW'(ci_ff) * XW'(bu_ff);
         p2_ff <= XW'(bi_ff) * XW'(cu_ff);
      end
      if (cmd.best_upd && !cand_m_ff && ci_ff != '0 && p1_ff > p2_ff) begin
         bi_ff   <= ci_ff;
         bu_ff   <= cu_ff;
         best_ff <= i_ff[DIW-1:0];
      end
      if (cmd.scan_step && confirmed) begin
         hd_x_ff   <= trk_x_ff[t_idx];
         hd_y_ff   <= trk_y_ff[t_idx];
         hd_w_ff   <= trk_w_ff[t_idx];
         hd_h_ff   <= trk_h_ff[t_idx];
         hd_tag_ff <= trk_tag_ff[t_idx];
      end
      if ((cmd.scan_step && status.scan_emit) || cmd.final_load) begin
         o_x_ff   <= held_v_ff ? FIELD_W'(hd_x_ff) : '0;
         o_y_ff   <= held_v_ff ? FIELD_W'(hd_y_ff) : '0;
         o_w_ff   <= held_v_ff ? FIELD_W'(hd_w_ff) : '0;
         o_h_ff   <= held_v_ff ? FIELD_W'(hd_h_ff) : '0;
         o_tag_ff <= held_v_ff ? hd_tag_ff : '0;
         pres_ff  <= held_v_ff;
         last_ff  <= cmd.final_load;
         ov_ff    <= drop_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_RESET;
         maxm_ff    <= MAXM_RESET;
         minh_ff    <= MINH_RESET;
         tc_ff      <= '0;
         fc_ff      <= '0;
         matched_ff <= '0;
         drop_ff    <= 1'b0;
         t_ff       <= '0;
         n_ff       <= '0;
         i_ff       <= '0;
         k_ff       <= '0;
         best_v_ff  <= 1'b0;
         match_ff   <= 1'b0;
         held_v_ff  <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MATCH_THRESHOLD:   thr_ff  <= csr_data;
               CSR_MAX_MISSED_FRAMES: maxm_ff <= csr_data[CNT_W-1:0];
               CSR_MIN_HITS_CONFIRM:  minh_ff <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.store_det) begin
            if (fc_ff < DCW'(MAX_DETS)) fc_ff <= fc_ff + 1'b1;
            else drop_ff <= 1'b1;
         end
         if (cmd.eof_start) t_ff <= '0;
         if (cmd.trk_load) begin
            i_ff      <= '0;
            best_v_ff <= 1'b0;
         end
         if (cmd.best_upd) begin
            i_ff <= i_ff + 1'b1;
            if (!cand_m_ff && ci_ff != '0 && p1_ff > p2_ff) best_v_ff <= 1'b1;
         end
         if (cmd.acc_calc) begin
            match_ff <= best_v_ff &&
                        (AW'({bi_ff, 8'd0}) >= AW'(thr_ff) * AW'(bu_ff));
         end
         if (cmd.trk_write) begin
            t_ff <= t_ff + 1'b1;
            if (match_ff) matched_ff[best_ff] <= 1'b1;
         end
         if (cmd.cmp_init) begin
            t_ff <= '0;
            n_ff <= '0;
         end
         if (cmd.cmp_step) begin
            t_ff <= t_ff + 1'b1;
            if (keep) n_ff <= n_ff + 1'b1;
         end
         if (cmd.cmp_done) begin
            tc_ff <= n_ff;
            i_ff  <= '0;
         end
         if (cmd.new_step) begin
            i_ff <= i_ff + 1'b1;
            if (!matched_ff[rd_idx]) begin
               if (tc_ff < TCW'(MAX_TRACKS)) tc_ff <= tc_ff + 1'b1;
               else drop_ff <= 1'b1;
            end
         end
         if (cmd.out_init) begin
            t_ff      <= '0;
            k_ff      <= '0;
            held_v_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            t_ff <= t_ff + 1'b1;
            if (confirmed) begin
               k_ff      <= k_ff + 1'b1;
               held_v_ff <= 1'b1;
            end
         end
         if ((cmd.scan_step && status.scan_emit) || cmd.final_load) rsp_tvalid <= 1'b1;
         else if (out_xfer) rsp_tvalid <= 1'b0;
         if (cmd.frame_clear) begin
            fc_ff      <= '0;
            matched_ff <= '0;
            drop_ff    <= 1'b0;
         end
      end
   end

   assign rsp_tdata = {o_tag_ff, o_h_ff, o_w_ff, o_y_ff, o_x_ff};
   assign rsp_tuser = {ov_ff, pres_ff};
   assign rsp_tlast = last_ff;

endmodule

### src/iou_greedy_track_association.sv
// Greedy IoU multi-object tracker. Detections (req_tuser = 0) are buffered at one
// transfer per cycle, up to MAX_DETS per frame; extra ones are dropped and flagged.
// An end-of-frame transfer (req_tuser = 1) starts the association pass, during which
// req_tready is low: each track is compared against every buffered detection in
// turn, one pair at a time through a shared overlap and cross-multiply unit, then
// its best match is scored and the track written back. After that, one pass over
// the tracks drops stale ones, one over the detections opens tracks for unmatched
// ones, and one over the tracks scans for reports. Confirmed tracks (up to
// RESULT_LIMIT) come out on rsp (rsp_tlast on the final one), or a single marker
// with present = 0 when none is confirmed. Register writes on the csr port are
// taken at any time and should only be issued while the block is idle.
module iou_greedy_track_association #(
   parameter int MAX_TRACKS = igta_pkg::MAX_TRACKS_DEF,
   parameter int MAX_DETS   = igta_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = igta_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [igta_pkg::DATA_W-1:0]    req_tdata,  // box_x, box_y, box_w, box_h, box_tag
   input  logic                           req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [igta_pkg::DATA_W-1:0]    rsp_tdata,  // out_x, out_y, out_w, out_h, out_tag
   output logic [1:0]                     rsp_tuser,  // present, overflow
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [igta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [igta_pkg::THR_W-1:0]     csr_data
);
   import igta_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   igta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   igta_dp #(
      .MAX_TRACKS (MAX_TRACKS),
      .MAX_DETS   (MAX_DETS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
